// File: design/vmlr_pkg.sv
// Shared constants, register indexes and sequencer states for the voice mix
// linear resampler. No dependencies; used by the core and its testbench.
package vmlr_pkg;

  // Default block length, handed to the top-level parameter.
  localparam int BLOCK_LEN_DEF = 40;

  // Field and datapath widths.
  localparam int NUM_VOICES = 6;
  localparam int VOICE_W    = 8;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 11;
  localparam int POS_W      = 23;
  localparam int FRAC_W     = 16;
  localparam int INT_W      = POS_W - 1 - FRAC_W;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 17;
  localparam int AMP_W      = 16;
  localparam int OUT_W      = 17;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 18;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MIX_SHIFT  = 6;
  localparam int OUT_SHIFT  = 31;
  localparam int MAX_RUN    = 64;
  localparam int RUN_W      = 7;
  localparam int VOICE_BIAS = 128;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_MASTER_GAIN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_AMPLITUDE = 2'd2;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd16384;
  localparam logic [STEP_W-1:0] STEP_RST = 17'd42667;
  localparam logic [AMP_W-1:0]  AMP_RST  = 16'd32767;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_MUL,
    ST_MIX_WR,
    ST_CHECK,
    ST_RD_B,
    ST_DIFF,
    ST_FRAC_MUL,
    ST_SUM,
    ST_AMP_MUL,
    ST_ROUND,
    ST_EMIT,
    ST_SWAP
  } state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_MIX,
    MUL_FRAC,
    MUL_AMP
  } mul_sel_t;

endpackage

// File: design/vmlr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds one bank of mixed samples.
module vmlr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/voice_mix_linear_resampler_core.sv
// Voice mixer with block-based linear-interpolation resampler.
// A frame that does not close a block is mixed and written; the frame that
// closes a block also yields its run of output words, one after another, each
// of which an output stall can hold back. One multiplier is shared by the mix
// gain, the interpolation and the amplitude scaling, so words are made in turn.
// Reset: synchronous; registers return to their defaults, the current block
// reads as zero until the first block is complete. No clearing pass is needed.
// Depends on vmlr_pkg and vmlr_ram.
module voice_mix_linear_resampler_core #(
  parameter int BLOCK_LEN = vmlr_pkg::BLOCK_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input frame channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [vmlr_pkg::VOICE_W-1:0]         voice_a,
  input  logic [vmlr_pkg::VOICE_W-1:0]         voice_b,
  input  logic [vmlr_pkg::VOICE_W-1:0]         voice_c,
  input  logic [vmlr_pkg::VOICE_W-1:0]         voice_d,
  input  logic [vmlr_pkg::VOICE_W-1:0]         voice_e,
  input  logic [vmlr_pkg::VOICE_W-1:0]         voice_f,
  // Output word channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [vmlr_pkg::OUT_W-1:0]    out_sample,
  output logic                                 last_of_run,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vmlr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [vmlr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [vmlr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int IDX_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_LEN - 1);
  localparam logic [vmlr_pkg::INT_W-1:0] LAST_INT = vmlr_pkg::INT_W'(BLOCK_LEN - 1);
  localparam logic signed [vmlr_pkg::POS_W-1:0] POS_LIMIT =
    vmlr_pkg::POS_W'(BLOCK_LEN * 65536 - 65601);
  localparam logic [vmlr_pkg::POS_W-1:0] BLOCK_SPAN = vmlr_pkg::POS_W'(BLOCK_LEN * 65536);
  localparam logic signed [vmlr_pkg::MUL_P_W-1:0] SAT_HI = vmlr_pkg::MUL_P_W'(32767);
  localparam logic signed [vmlr_pkg::MUL_P_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [vmlr_pkg::MUL_P_W-1:0] MIX_HALF =
    vmlr_pkg::MUL_P_W'(1 << (vmlr_pkg::MIX_SHIFT - 1));

  // Configuration registers.
  logic [vmlr_pkg::GAIN_W-1:0] master_gain;
  logic [vmlr_pkg::STEP_W-1:0] step_size;
  logic [vmlr_pkg::AMP_W-1:0]  out_amplitude;
  logic                        cfg_write;
  logic [vmlr_pkg::REG_IDX_W-1:0] cfg_idx;

  // Sequencer and block state.
  vmlr_pkg::state_t state, state_next;
  logic [IDX_W-1:0]                  fill_count;
  logic                              cur_bank;
  logic                              cur_valid;
  logic signed [vmlr_pkg::POS_W-1:0] pos;
  logic [vmlr_pkg::RUN_W-1:0]        run_count;

  // Datapath registers.
  logic signed [vmlr_pkg::SUM_W-1:0]    sum_q;
  logic signed [vmlr_pkg::SAMPLE_W-1:0] a_q;
  logic signed [vmlr_pkg::DIFF_W-1:0]   diff_q;
  logic [vmlr_pkg::FRAC_W-1:0]          frac_q;
  logic [IDX_W-1:0]                     nxt_q;
  logic signed [vmlr_pkg::MUL_A_W-1:0]  x_q;
  logic signed [vmlr_pkg::OUT_W-1:0]    res_q;
  logic signed [vmlr_pkg::MUL_P_W-1:0]  mul_p;

  // Control from the output decoder.
  logic                   in_take;
  logic                   mul_en;
  vmlr_pkg::mul_sel_t     mul_sel;
  logic                   wr_en;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_idx;
  logic                   load_out;

  // Combinational helpers.
  logic [vmlr_pkg::VOICE_W-1:0]         voices [vmlr_pkg::NUM_VOICES];
  logic [vmlr_pkg::SUM_W-1:0]           voice_total;
  logic signed [vmlr_pkg::SUM_W-1:0]    voice_sum_c;
  logic signed [vmlr_pkg::MUL_P_W-1:0]  mix_round_c;
  logic signed [vmlr_pkg::SAMPLE_W-1:0] mix_sat_c;
  logic                                 pos_neg;
  logic [vmlr_pkg::INT_W-1:0]           int_raw;
  logic [IDX_W-1:0]                     idx_c;
  logic [IDX_W-1:0]                     nxt_c;
  logic [vmlr_pkg::FRAC_W-1:0]          frac_c;
  logic                                 run_go;
  logic                                 out_free;
  logic signed [vmlr_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [vmlr_pkg::MUL_B_W-1:0]  mul_b;
  logic [vmlr_pkg::MUL_P_W-1:0]         y_abs;
  logic [vmlr_pkg::OUT_W-1:0]           y_mag;
  logic [vmlr_pkg::SAMPLE_W-1:0]        rd_data0;
  logic [vmlr_pkg::SAMPLE_W-1:0]        rd_data1;
  logic signed [vmlr_pkg::SAMPLE_W-1:0] rd_val;

  // Configuration port: always ready, writes at the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = paddr[vmlr_pkg::REG_IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain   <= vmlr_pkg::GAIN_RST;
      step_size     <= vmlr_pkg::STEP_RST;
      out_amplitude <= vmlr_pkg::AMP_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        vmlr_pkg::REG_MASTER_GAIN:   master_gain   <= pwdata[vmlr_pkg::GAIN_W-1:0];
        vmlr_pkg::REG_STEP_SIZE:     step_size     <= pwdata[vmlr_pkg::STEP_W-1:0];
        vmlr_pkg::REG_OUT_AMPLITUDE: out_amplitude <= pwdata[vmlr_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vmlr_pkg::REG_MASTER_GAIN:
        prdata = vmlr_pkg::APB_DATA_W'(master_gain);
      vmlr_pkg::REG_STEP_SIZE:
        prdata = vmlr_pkg::APB_DATA_W'(step_size);
      vmlr_pkg::REG_OUT_AMPLITUDE:
        prdata = vmlr_pkg::APB_DATA_W'(out_amplitude);
      default:
        prdata = '0;
    endcase
  end

  // Voice sum, recentred at the bias value.
  assign voices[0] = voice_a;
  assign voices[1] = voice_b;
  assign voices[2] = voice_c;
  assign voices[3] = voice_d;
  assign voices[4] = voice_e;
  assign voices[5] = voice_f;

  always_comb begin
    voice_total = '0;
    for (int v = 0; v < vmlr_pkg::NUM_VOICES; v++) begin
      voice_total = voice_total + vmlr_pkg::SUM_W'(voices[v]);
    end
    voice_sum_c = $signed(voice_total -
                          vmlr_pkg::SUM_W'(vmlr_pkg::NUM_VOICES * vmlr_pkg::VOICE_BIAS));
  end

  // Mix rounding to Q1.15, ties upwards, then saturation.
  always_comb begin
    mix_round_c = (mul_p + MIX_HALF) >>> vmlr_pkg::MIX_SHIFT;
    if (mix_round_c > SAT_HI) begin
      mix_sat_c = SAT_HI[vmlr_pkg::SAMPLE_W-1:0];
    end else if (mix_round_c < SAT_LO) begin
      mix_sat_c = SAT_LO[vmlr_pkg::SAMPLE_W-1:0];
    end else begin
      mix_sat_c = mix_round_c[vmlr_pkg::SAMPLE_W-1:0];
    end
  end

  // Read position split into clamped indexes and fraction.
  assign pos_neg = pos[vmlr_pkg::POS_W-1];
  assign int_raw = pos[vmlr_pkg::POS_W-2:vmlr_pkg::FRAC_W];

  always_comb begin
    if (pos_neg) begin
      idx_c  = '0;
      frac_c = '0;
    end else begin
      idx_c  = (int_raw > LAST_INT) ? LAST_IDX : int_raw[IDX_W-1:0];
      frac_c = pos[vmlr_pkg::FRAC_W-1:0];
    end
    nxt_c = (idx_c == LAST_IDX) ? idx_c : idx_c + IDX_W'(1);
  end

  assign run_go   = (run_count < vmlr_pkg::RUN_W'(vmlr_pkg::MAX_RUN)) && (pos < POS_LIMIT);
  assign out_free = !out_valid || !out_stall;

  // Scaled output: magnitude shifted down, so rounding is toward zero.
  assign y_abs = mul_p[vmlr_pkg::MUL_P_W-1] ? vmlr_pkg::MUL_P_W'(-mul_p)
                                            : vmlr_pkg::MUL_P_W'(mul_p);
  assign y_mag = y_abs[vmlr_pkg::OUT_SHIFT +: vmlr_pkg::OUT_W];

  // Two sample banks: one fills while the other is read.
  vmlr_ram #(
    .WIDTH (vmlr_pkg::SAMPLE_W),
    .DEPTH (BLOCK_LEN)
  ) u_bank0 (
    .clk   (clk),
    .we    (wr_en & cur_bank),
    .waddr (fill_count),
    .wdata (mix_sat_c),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rd_data0)
  );

  vmlr_ram #(
    .WIDTH (vmlr_pkg::SAMPLE_W),
    .DEPTH (BLOCK_LEN)
  ) u_bank1 (
    .clk   (clk),
    .we    (wr_en & ~cur_bank),
    .waddr (fill_count),
    .wdata (mix_sat_c),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rd_data1)
  );

  // Before the first complete block the current block reads as zero.
  assign rd_val = !cur_valid ? '0 : (cur_bank ? $signed(rd_data1) : $signed(rd_data0));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      vmlr_pkg::ST_IDLE:     if (in_valid) state_next = vmlr_pkg::ST_MIX_MUL;
      vmlr_pkg::ST_MIX_MUL:  state_next = vmlr_pkg::ST_MIX_WR;
      vmlr_pkg::ST_MIX_WR:   state_next = (fill_count == LAST_IDX) ? vmlr_pkg::ST_CHECK
                                                                   : vmlr_pkg::ST_IDLE;
      vmlr_pkg::ST_CHECK:    state_next = run_go ? vmlr_pkg::ST_RD_B : vmlr_pkg::ST_SWAP;
      vmlr_pkg::ST_RD_B:     state_next = vmlr_pkg::ST_DIFF;
      vmlr_pkg::ST_DIFF:     state_next = vmlr_pkg::ST_FRAC_MUL;
      vmlr_pkg::ST_FRAC_MUL: state_next = vmlr_pkg::ST_SUM;
      vmlr_pkg::ST_SUM:      state_next = vmlr_pkg::ST_AMP_MUL;
      vmlr_pkg::ST_AMP_MUL:  state_next = vmlr_pkg::ST_ROUND;
      vmlr_pkg::ST_ROUND:    state_next = vmlr_pkg::ST_EMIT;
      vmlr_pkg::ST_EMIT:     if (out_free) state_next = vmlr_pkg::ST_CHECK;
      vmlr_pkg::ST_SWAP:     state_next = vmlr_pkg::ST_IDLE;
      default:               state_next = vmlr_pkg::ST_IDLE;
    endcase
  end

  // Output decoder for the sequencer. No word is taken while reset is held.
  always_comb begin
    in_stall = 1'b1;
    in_take  = 1'b0;
    mul_en   = 1'b0;
    mul_sel  = vmlr_pkg::MUL_MIX;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = idx_c;
    load_out = 1'b0;
    case (state)
      vmlr_pkg::ST_IDLE: begin
        in_stall = rst;
        in_take  = in_valid & ~rst;
      end
      vmlr_pkg::ST_MIX_MUL: begin
        mul_en  = 1'b1;
        mul_sel = vmlr_pkg::MUL_MIX;
      end
      vmlr_pkg::ST_MIX_WR: begin
        wr_en = 1'b1;
      end
      vmlr_pkg::ST_CHECK: begin
        rd_en  = run_go;
        rd_idx = idx_c;
      end
      vmlr_pkg::ST_RD_B: begin
        rd_en  = 1'b1;
        rd_idx = nxt_q;
      end
      vmlr_pkg::ST_FRAC_MUL: begin
        mul_en  = 1'b1;
        mul_sel = vmlr_pkg::MUL_FRAC;
      end
      vmlr_pkg::ST_AMP_MUL: begin
        mul_en  = 1'b1;
        mul_sel = vmlr_pkg::MUL_AMP;
      end
      vmlr_pkg::ST_EMIT: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (mul_sel)
      vmlr_pkg::MUL_MIX: begin
        mul_a = vmlr_pkg::MUL_A_W'(sum_q);
        mul_b = $signed(vmlr_pkg::MUL_B_W'(master_gain));
      end
      vmlr_pkg::MUL_FRAC: begin
        mul_a = vmlr_pkg::MUL_A_W'(diff_q);
        mul_b = $signed(vmlr_pkg::MUL_B_W'(frac_q));
      end
      vmlr_pkg::MUL_AMP: begin
        mul_a = x_q;
        mul_b = $signed(vmlr_pkg::MUL_B_W'(out_amplitude));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_p <= mul_a * mul_b;
    end
  end

  // Sequencer state and block bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vmlr_pkg::ST_IDLE;
      fill_count <= '0;
      cur_bank   <= 1'b0;
      cur_valid  <= 1'b0;
      pos        <= '0;
      run_count  <= '0;
    end else begin
      state <= state_next;
      case (state)
        vmlr_pkg::ST_MIX_WR: begin
          if (fill_count != LAST_IDX) begin
            fill_count <= fill_count + IDX_W'(1);
          end
        end
        vmlr_pkg::ST_ROUND: begin
          pos       <= pos + $signed(vmlr_pkg::POS_W'(step_size));
          run_count <= run_count + vmlr_pkg::RUN_W'(1);
        end
        vmlr_pkg::ST_SWAP: begin
          cur_bank   <= ~cur_bank;
          cur_valid  <= 1'b1;
          pos        <= pos - $signed(BLOCK_SPAN);
          fill_count <= '0;
          run_count  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, loaded by state.
  always_ff @(posedge clk) begin
    if (in_take) begin
      sum_q <= voice_sum_c;
    end
    case (state)
      vmlr_pkg::ST_CHECK: begin
        frac_q <= frac_c;
        nxt_q  <= nxt_c;
      end
      vmlr_pkg::ST_RD_B: begin
        a_q <= rd_val;
      end
      vmlr_pkg::ST_DIFF: begin
        diff_q <= vmlr_pkg::DIFF_W'(rd_val) - vmlr_pkg::DIFF_W'(a_q);
      end
      vmlr_pkg::ST_SUM: begin
        x_q <= (vmlr_pkg::MUL_A_W'(a_q) <<< vmlr_pkg::FRAC_W) +
               mul_p[vmlr_pkg::MUL_A_W-1:0];
      end
      vmlr_pkg::ST_ROUND: begin
        res_q <= mul_p[vmlr_pkg::MUL_P_W-1] ? $signed(-y_mag) : $signed(y_mag);
      end
      default: ;
    endcase
  end

  // Output register: the word is flagged last when no further output is due.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample  <= res_q;
      last_of_run <= !run_go;
    end
  end

endmodule

// File: verif/voice_mix_linear_resampler_core_tb.sv
// Self-checking testbench for voice_mix_linear_resampler_core: frames are mixed,
// resampled and scaled by a predictor in the bench and every output word is checked.
// Depends on vmlr_pkg and the core RTL only.
module voice_mix_linear_resampler_core_tb;

  localparam int     BLK          = vmlr_pkg::BLOCK_LEN_DEF;
  localparam longint POS_LIMIT    = longint'(BLK) * 65536 - 65601;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     LONG_HOLD    = 200;

  typedef logic [vmlr_pkg::NUM_VOICES-1:0][vmlr_pkg::VOICE_W-1:0] frame_t;

  typedef struct {
    logic signed [vmlr_pkg::OUT_W-1:0] sample;
    logic                              last;
  } word_t;

  // Clock, reset and block ports; every input is driven to a known value from time zero.
  logic                                clk         = 1'b0;
  logic                                rst         = 1'b1;
  logic                                in_valid    = 1'b0;
  logic                                in_stall;
  logic [vmlr_pkg::VOICE_W-1:0]        voice_a     = '0;
  logic [vmlr_pkg::VOICE_W-1:0]        voice_b     = '0;
  logic [vmlr_pkg::VOICE_W-1:0]        voice_c     = '0;
  logic [vmlr_pkg::VOICE_W-1:0]        voice_d     = '0;
  logic [vmlr_pkg::VOICE_W-1:0]        voice_e     = '0;
  logic [vmlr_pkg::VOICE_W-1:0]        voice_f     = '0;
  logic                                out_valid;
  logic                                out_stall   = 1'b0;
  logic signed [vmlr_pkg::OUT_W-1:0]   out_sample;
  logic                                last_of_run;
  logic                                psel        = 1'b0;
  logic                                penable     = 1'b0;
  logic                                pwrite      = 1'b0;
  logic [vmlr_pkg::APB_ADDR_W-1:0]     paddr       = '0;
  logic [vmlr_pkg::APB_DATA_W-1:0]     pwdata      = '0;
  logic [vmlr_pkg::APB_DATA_W-1:0]     prdata;
  logic                                pready;

  // Predictor state: register copies, the two sample blocks and the read position.
  logic [vmlr_pkg::GAIN_W-1:0]          cfg_gain = vmlr_pkg::GAIN_RST;
  logic [vmlr_pkg::STEP_W-1:0]          cfg_step = vmlr_pkg::STEP_RST;
  logic [vmlr_pkg::AMP_W-1:0]           cfg_amp  = vmlr_pkg::AMP_RST;
  logic signed [vmlr_pkg::SAMPLE_W-1:0] current_blk [BLK];
  logic signed [vmlr_pkg::SAMPLE_W-1:0] fill_blk    [BLK];
  int                                   fill_cnt = 0;
  logic signed [vmlr_pkg::POS_W-1:0]    rd_pos   = '0;

  word_t                        due_words [$];
  word_t                        head_word;
  int                           err_cnt    = 0;
  bit                           idle_en    = 1'b1;
  bit                           hold_armed = 1'b0;

  voice_mix_linear_resampler_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .voice_a     (voice_a),
    .voice_b     (voice_b),
    .voice_c     (voice_c),
    .voice_d     (voice_d),
    .voice_e     (voice_e),
    .voice_f     (voice_f),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .last_of_run (last_of_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Recentre, sum and apply the master gain; round half up to Q1.15 and saturate.
  function automatic logic signed [vmlr_pkg::SAMPLE_W-1:0] mix_voices(input frame_t f);
    longint acc;
    longint q;
    acc = 0;
    for (int i = 0; i < vmlr_pkg::NUM_VOICES; i++)
      acc += longint'(f[i]) - vmlr_pkg::VOICE_BIAS;
    q = (acc * longint'(cfg_gain) + 32) >>> vmlr_pkg::MIX_SHIFT;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[vmlr_pkg::SAMPLE_W-1:0];
  endfunction

  // Linear interpolation at the read position, scaled and truncated toward zero.
  function automatic logic signed [vmlr_pkg::OUT_W-1:0] interp_sample();
    longint p, idx, nxt, frac, a, b, y, mag, res;
    p    = longint'(rd_pos);
    idx  = 0;
    frac = 0;
    if (p >= 0) begin
      idx  = p / 65536;
      frac = p % 65536;
    end
    if (idx > BLK - 1) idx = BLK - 1;
    nxt = idx + 1;
    if (nxt > BLK - 1) nxt = BLK - 1;
    a   = longint'(current_blk[idx]);
    b   = longint'(current_blk[nxt]);
    y   = (a * 65536 + frac * (b - a)) * longint'(cfg_amp);
    mag = (y < 0 ? -y : y) >> vmlr_pkg::OUT_SHIFT;
    res = y < 0 ? -mag : mag;
    return res[vmlr_pkg::OUT_W-1:0];
  endfunction

  // Store a mixed frame; a full block releases the run of words still due.
  function automatic void accept_frame(input frame_t f);
    word_t  run_q [$];
    word_t  w;
    longint t;
    fill_blk[fill_cnt] = mix_voices(f);
    fill_cnt++;
    if (fill_cnt < BLK) return;
    while (run_q.size() < vmlr_pkg::MAX_RUN && longint'(rd_pos) < POS_LIMIT) begin
      w.sample = interp_sample();
      w.last   = 1'b0;
      run_q.push_back(w);
      t      = longint'(rd_pos) + longint'(cfg_step);
      rd_pos = t[vmlr_pkg::POS_W-1:0];
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) due_words.push_back(run_q[i]);
    current_blk = fill_blk;
    t           = longint'(rd_pos) - longint'(BLK) * 65536;
    rd_pos      = t[vmlr_pkg::POS_W-1:0];
    fill_cnt    = 0;
  endfunction

  // Random frame: half the time close to silence so that the mix is not always clipped.
  function automatic frame_t rand_frame();
    frame_t f;
    bit     quiet;
    quiet = 1'($urandom_range(0, 1));
    for (int i = 0; i < vmlr_pkg::NUM_VOICES; i++)
      f[i] = quiet ? vmlr_pkg::VOICE_W'($urandom_range(120, 136))
                   : vmlr_pkg::VOICE_W'($urandom_range(0, 255));
    return f;
  endfunction

  // Offer one frame and hold it until the block takes it. Entered and left at a falling edge.
  task automatic send_frame(input frame_t f);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    voice_a  <= f[0];
    voice_b  <= f[1];
    voice_c  <= f[2];
    voice_d  <= f[3];
    voice_e  <= f[4];
    voice_f  <= f[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accept_frame(f);
    @(negedge clk);
  endtask

  // Random frames; optionally pause after each closing frame until its run has drained.
  task automatic run_frames(input int count, input bit pause_on_close);
    for (int i = 0; i < count; i++) begin
      send_frame(rand_frame());
      if (pause_on_close && fill_cnt == 0) begin
        in_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge clk);
      end
    end
  endtask

  // Wait until no word is due, then let a frame still in flight finish.
  task automatic close_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register over the configuration port, then read it back.
  task automatic set_reg(input logic [vmlr_pkg::REG_IDX_W-1:0] idx,
                         input logic [vmlr_pkg::APB_DATA_W-1:0] val);
    logic [vmlr_pkg::APB_DATA_W-1:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      vmlr_pkg::REG_MASTER_GAIN:   cfg_gain = val[vmlr_pkg::GAIN_W-1:0];
      vmlr_pkg::REG_STEP_SIZE:     cfg_step = val[vmlr_pkg::STEP_W-1:0];
      vmlr_pkg::REG_OUT_AMPLITUDE: cfg_amp  = val[vmlr_pkg::AMP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      vmlr_pkg::REG_MASTER_GAIN: held = vmlr_pkg::APB_DATA_W'(cfg_gain);
      vmlr_pkg::REG_STEP_SIZE:   held = vmlr_pkg::APB_DATA_W'(cfg_step);
      default:                   held = vmlr_pkg::APB_DATA_W'(cfg_amp);
    endcase
    if (prdata !== held) begin
      $display("%0t: register %0d read back expected %0d, got %0d", $time, idx, held, prdata);
      err_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Defaults after reset: field extremes, clipping edges and one-voice frames.
  task automatic test_directed_extremes();
    frame_t f;
    for (int k = 0; k < 21; k++) begin
      f = {vmlr_pkg::NUM_VOICES{8'd128}};
      case (k)
        0:  f = '0;
        1:  f = {vmlr_pkg::NUM_VOICES{8'd255}};
        2:  ;
        3:  f = {vmlr_pkg::NUM_VOICES/2{8'd255, 8'd0}};
        4:  f = {vmlr_pkg::NUM_VOICES/2{8'd0, 8'd255}};
        17: begin f[0] = 8'd255; f[1] = 8'd129; end
        18: begin f[0] = 8'd0;   f[1] = 8'd127; end
        19: f = {vmlr_pkg::NUM_VOICES/2{8'h55, 8'haa}};
        20: f = {vmlr_pkg::NUM_VOICES/2{8'haa, 8'h55}};
        default: f[(k - 5) % vmlr_pkg::NUM_VOICES] = (k < 11) ? 8'd255 : 8'd0;
      endcase
      send_frame(f);
    end
    run_frames(BLK - fill_cnt, 1'b0);
    close_phase();
  endtask

  // Largest gain and amplitude with step 65536; the receiver holds off long enough to back up the input.
  task automatic test_max_settings_long_hold();
    set_reg(vmlr_pkg::REG_MASTER_GAIN, 32'd65535);
    set_reg(vmlr_pkg::REG_STEP_SIZE, 32'd65536);
    set_reg(vmlr_pkg::REG_OUT_AMPLITUDE, 32'd65535);
    hold_armed = 1'b1;
    run_frames(BLK - fill_cnt + 12, 1'b0);
    close_phase();
  endtask

  // Zero step: the run is cut at its maximum length at a position below zero.
  // The sender waits for the whole run before going on.
  task automatic test_zero_step_pause();
    set_reg(vmlr_pkg::REG_MASTER_GAIN, 32'd12000);
    set_reg(vmlr_pkg::REG_STEP_SIZE, 32'd0);
    set_reg(vmlr_pkg::REG_OUT_AMPLITUDE, 32'd40000);
    run_frames(BLK - fill_cnt + 10, 1'b1);
    close_phase();
  endtask

  // Zero gain and amplitude with a second long run; the position then wraps round.
  task automatic test_overrun_and_wrap();
    set_reg(vmlr_pkg::REG_MASTER_GAIN, 32'd0);
    set_reg(vmlr_pkg::REG_OUT_AMPLITUDE, 32'd0);
    run_frames(BLK - fill_cnt, 1'b0);
    close_phase();
  endtask

  // A step of 40960 from a position past the limit: the closing frame yields no words.
  task automatic test_silent_block();
    set_reg(vmlr_pkg::REG_MASTER_GAIN, 32'($urandom_range(0, 65535)));
    set_reg(vmlr_pkg::REG_STEP_SIZE, 32'd40960);
    set_reg(vmlr_pkg::REG_OUT_AMPLITUDE, 32'($urandom_range(0, 65535)));
    run_frames(BLK - fill_cnt, 1'b0);
    close_phase();
  endtask

  // Random settings at full rate on both sides.
  task automatic test_random_no_idle();
    set_reg(vmlr_pkg::REG_MASTER_GAIN, 32'($urandom_range(4096, 32768)));
    set_reg(vmlr_pkg::REG_STEP_SIZE, 32'($urandom_range(40960, 65536)));
    set_reg(vmlr_pkg::REG_OUT_AMPLITUDE, 32'($urandom_range(0, 65535)));
    idle_en = 1'b0;
    run_frames(BLK - fill_cnt, 1'b0);
    close_phase();
  endtask

  // Receiver: random stall bursts, and one long hold-off when armed.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_armed && out_valid) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_armed = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted word with the oldest one due.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got sample %0d last %0b",
                 $time, out_sample, last_of_run);
        err_cnt++;
      end else begin
        head_word = due_words.pop_front();
        if (out_sample !== head_word.sample) begin
          $display("%0t: out_sample expected %0d, got %0d", $time, head_word.sample, out_sample);
          err_cnt++;
        end
        if (last_of_run !== head_word.last) begin
          $display("%0t: last_of_run expected %0b, got %0b", $time, head_word.last, last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    foreach (current_blk[i]) current_blk[i] = '0;
    foreach (fill_blk[i]) fill_blk[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_extremes();
    test_max_settings_long_hold();
    test_zero_step_pause();
    test_overrun_and_wrap();
    test_silent_block();
    test_random_no_idle();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
